/* rtl/i2cee_pkg.sv */
// ----------------------------------------------------------------------------
// I2C EEPROM emulator package
// Shared types and constants for the I2C target EEPROM emulator.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

  localparam int unsigned PtrW   = 13;
  localparam int unsigned AddrW  = 12;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ActW   = 3;

  localparam logic [SizeW-1:0] SizeReset = 13'd64;
  localparam int unsigned      SizeLimit = 4096;

  typedef enum logic [ActW-1:0] {
    ActRxByte = 3'd0,
    ActRdReq  = 3'd1,
    ActStop   = 3'd2,
    ActHostWr = 3'd3,
    ActHostRd = 3'd4
  } action_e;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [ByteW-1:0] data_byte;
    logic             new_write;
    logic             slave_active;
    logic [AddrW-1:0] host_addr;
    logic             poll_only;
  } item_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] wdata;
  } mem_req_t;

  // What the result stage needs to know about one word.
  typedef struct packed {
    logic tx_valid;
    logic host_rd;
    logic host_ok;
    logic data_pending;
  } meta_t;

endpackage

`default_nettype wire

/* rtl/i2cee_mem.sv */
// ----------------------------------------------------------------------------
// I2C EEPROM emulator byte store
// Single-port byte memory with registered read data and a zeroing sweep
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_mem
  import i2cee_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mem_req_t         req_i,
  output logic [ByteW-1:0]      rdata_o,
  output logic                  busy_o
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  logic [ByteW-1:0] mem_q [MEM_DEPTH];
  logic [ByteW-1:0] rdata_q;
  logic [AW-1:0]    clr_q;
  logic             busy_q;

  // The sweep writes one zero byte per cycle, from address zero upwards.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == AW'(MEM_DEPTH - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= '0;
    end else if (req_i.we) begin
      mem_q[AW'(req_i.addr)] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[AW'(req_i.addr)];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

/* rtl/i2cee_ctrl.sv */
// ----------------------------------------------------------------------------
// I2C EEPROM emulator control
// Byte pointer and phase bookkeeping; turns each word into at most one memory
// access and the flags of its result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_ctrl
  import i2cee_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire item_t            item_i,
  input  wire logic [SizeW-1:0] buffer_size_i,
  output mem_req_t              mem_req_o,
  output meta_t                 meta_o
);

  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            off_q, off_d;
  logic            wp_q, wp_d;
  logic            rp_q, rp_d;
  logic            pend_q, pend_d;

  logic [PtrW-1:0] ptr_a;
  logic            off_a;
  logic [PtrW-1:0] ptr_w;
  logic [PtrW-1:0] ptr_r;
  logic [PtrW-1:0] ptr_rw;
  logic            addr_in_range;

  always_comb begin
    // Pointer and offset flag after a write phase start or a restart.
    ptr_a = ptr_q;
    off_a = off_q;
    if (!wp_q || item_i.new_write) begin
      ptr_a = '0;
      off_a = 1'b0;
    end
    ptr_w  = (ptr_a >= buffer_size_i) ? '0 : ptr_a;
    ptr_r  = rp_q ? (ptr_q + 1'b1) : ptr_q;
    ptr_rw = (ptr_r >= buffer_size_i) ? '0 : ptr_r;
    addr_in_range = ({1'b0, item_i.host_addr} < buffer_size_i);
  end

  always_comb begin
    ptr_d     = ptr_q;
    off_d     = off_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    pend_d    = pend_q;
    mem_req_o = '0;
    meta_o    = '0;
    unique case (action_e'(item_i.action))
      ActRxByte: begin
        wp_d = 1'b1;
        if (!wp_q) begin
          rp_d = 1'b0;
        end
        if (off_a) begin
          mem_req_o.we    = fire_i;
          mem_req_o.addr  = ptr_w[AddrW-1:0];
          mem_req_o.wdata = item_i.data_byte;
          ptr_d           = ptr_w + 1'b1;
          pend_d          = 1'b1;
          off_d           = 1'b1;
        end else begin
          off_d = 1'b1;
          ptr_d = PtrW'(item_i.data_byte);
        end
      end
      ActRdReq: begin
        if (item_i.slave_active) begin
          rp_d            = 1'b1;
          wp_d            = rp_q ? wp_q : 1'b0;
          ptr_d           = ptr_rw;
          mem_req_o.re    = fire_i;
          mem_req_o.addr  = ptr_rw[AddrW-1:0];
          meta_o.tx_valid = 1'b1;
        end
      end
      ActStop: begin
        ptr_d = '0;
        off_d = 1'b0;
      end
      ActHostWr: begin
        if (addr_in_range) begin
          mem_req_o.we    = fire_i;
          mem_req_o.addr  = item_i.host_addr;
          mem_req_o.wdata = item_i.data_byte;
          meta_o.host_ok  = 1'b1;
        end
      end
      ActHostRd: begin
        if (item_i.poll_only) begin
          meta_o.data_pending = pend_q;
          pend_d              = 1'b0;
        end else if (addr_in_range) begin
          mem_req_o.re   = fire_i;
          mem_req_o.addr = item_i.host_addr;
          meta_o.host_rd = 1'b1;
          meta_o.host_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      off_q  <= 1'b0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      pend_q <= 1'b0;
    end else if (fire_i) begin
      ptr_q  <= ptr_d;
      off_q  <= off_d;
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/i2c_slave_eeprom_emulator.sv */
// ----------------------------------------------------------------------------
// I2C target EEPROM emulator
// Byte memory behind I2C bus events and direct host accesses. Each word in
// gives one result word out; three stages: input register, control and
// memory access, result register. One word can be taken every cycle while
// the result path is not stalled, as the single memory port serves at most
// one access per word. After reset the memory is zeroed by a sweep, during
// which no word is accepted; buffer size writes are taken at all times and
// writes of zero or beyond the memory or SizeLimit are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_slave_eeprom_emulator
  import i2cee_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [SizeW-1:0] cfg_buffer_size_i,
  // Input words
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ActW-1:0]  action_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             new_write_i,
  input  wire logic             slave_active_i,
  input  wire logic [AddrW-1:0] host_addr_i,
  input  wire logic             poll_only_i,
  // Result words
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  tx_valid_o,
  output logic [ByteW-1:0]      tx_byte_o,
  output logic [ByteW-1:0]      host_data_o,
  output logic                  host_ok_o,
  output logic                  data_pending_o
);

  localparam int unsigned SizeMax = (MEM_DEPTH < SizeLimit) ? MEM_DEPTH : SizeLimit;

  logic [SizeW-1:0] buf_size_q;
  logic             s1_v_q;
  item_t            s1_item_q;
  logic             s2_v_q;
  meta_t            s2_meta_q;
  logic             out_v_q;
  logic             tx_valid_q;
  logic [ByteW-1:0] tx_byte_q;
  logic [ByteW-1:0] host_data_q;
  logic             host_ok_q;
  logic             pend_q;

  logic             en_out, en2, en1, fire;
  logic             mem_busy;
  logic [ByteW-1:0] mem_rdata;
  mem_req_t         mem_req;
  meta_t            meta;

  // Buffer size register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= SizeReset;
    end else if (cfg_valid_i && (cfg_buffer_size_i != '0) &&
                 (32'(cfg_buffer_size_i) <= SizeMax)) begin
      buf_size_q <= cfg_buffer_size_i;
    end
  end

  // Each stage moves when it is empty or its successor moves.
  assign en_out     = !out_v_q || out_ready_i;
  assign en2        = !s2_v_q || en_out;
  assign en1        = !s1_v_q || en2;
  assign in_ready_o = en1 && !mem_busy;
  assign fire       = en2 && s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= in_valid_i && in_ready_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q.action       <= action_i;
      s1_item_q.data_byte    <= data_byte_i;
      s1_item_q.new_write    <= new_write_i;
      s1_item_q.slave_active <= slave_active_i;
      s1_item_q.host_addr    <= host_addr_i;
      s1_item_q.poll_only    <= poll_only_i;
    end
  end

  i2cee_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (s1_item_q),
    .buffer_size_i (buf_size_q),
    .mem_req_o     (mem_req),
    .meta_o        (meta)
  );

  i2cee_mem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_meta_q <= meta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= s2_v_q;
    end
  end

  // The read data register holds while its word waits in the second stage.
  always_ff @(posedge clk_i) begin
    if (en_out) begin
      tx_valid_q  <= s2_meta_q.tx_valid;
      tx_byte_q   <= s2_meta_q.tx_valid ? mem_rdata : '0;
      host_data_q <= s2_meta_q.host_rd ? mem_rdata : '0;
      host_ok_q   <= s2_meta_q.host_ok;
      pend_q      <= s2_meta_q.data_pending;
    end
  end

  assign out_valid_o    = out_v_q;
  assign tx_valid_o     = tx_valid_q;
  assign tx_byte_o      = tx_byte_q;
  assign host_data_o    = host_data_q;
  assign host_ok_o      = host_ok_q;
  assign data_pending_o = pend_q;

`ifndef SYNTHESIS
  a_no_accept_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> !in_ready_o && !s1_v_q && !mem_req.we && !mem_req.re)
    else $error("word taken or memory accessed during the clearing sweep");

  a_size_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_size_q != '0) && (32'(buf_size_q) <= SizeMax))
    else $error("buffer size register holds an illegal value");

  a_one_kind_of_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(tx_valid_o && host_ok_o) && !(data_pending_o && (tx_valid_o || host_ok_o)))
    else $error("result word carries more than one kind of answer");

  a_single_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("memory read and write requested in the same cycle");
`endif

endmodule

`default_nettype wire
